@@ rtl/sla_pkg.sv @@
// Shared widths, codes and register indexes of the semi-Lagrangian advection block.
// No dependencies; sla_mul, the top level and the testbench use this package.
package sla_pkg;

  localparam int GRID_MAX = 126;
  localparam int SIDE     = GRID_MAX + 2;
  localparam int IDX_W    = 7;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = IDX_W + FRAC_W;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DATA_W   = 32;
  localparam int STEP_W   = 24;
  localparam int CFG_W    = 24;

  localparam int OPA_W    = STEP_W + 1;
  localparam int OPB_W    = 36;
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int OFF_W    = 41;
  localparam int ACC_W    = 37;

  localparam logic [IDX_W-1:0]  GRID_MAX_C   = IDX_W'(GRID_MAX);
  localparam logic [IDX_W-1:0]  GRID_CELLS_RST = 7'd126;
  localparam logic [STEP_W-1:0] STEP_SCALE_RST = 24'd65536;

  localparam logic CFG_GRID_CELLS = 1'b0;
  localparam logic CFG_STEP_SCALE = 1'b1;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_ADVECT = 1'b1;

endpackage

@@ rtl/sla_ram.sv @@
// Generic single-port RAM with registered read data.
// Holds the bordered source grid; no package dependencies.
module sla_ram #(
  parameter int DW = 32,
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

@@ rtl/sla_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on sla_pkg for operand and product widths.
module sla_mul (
  input  logic                                clk,
  input  logic signed [sla_pkg::OPA_W-1:0]    op_a,
  input  logic signed [sla_pkg::OPB_W-1:0]    op_b,
  output logic signed [sla_pkg::PROD_W-1:0]   prod_r
);
  import sla_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

@@ rtl/semi_lagrangian_advection.sv @@
// Top level of the semi-Lagrangian advection block: sequencer, configuration and result registers.
// Depends on sla_pkg, sla_ram and sla_mul.
//
// A load transfer writes one grid sample in the cycle it is accepted and leaves busy low.
// An advect transfer holds busy high through its final state S_FIN; its result is strobed on
// out_valid, registered from S_FIN, and no new transfer is taken while busy is high. The
// sequence is set by the one shared multiplier, which does the two back-trace products and the
// six interpolation products in turn, and by the single grid memory port, which delivers the
// four neighboring samples one per cycle. The result is shown for exactly one cycle and
// cannot be stalled. Grid entries read by an advect must have been loaded beforehand.
module semi_lagrangian_advection (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [sla_pkg::IDX_W-1:0]          in_row,
  input  logic [sla_pkg::IDX_W-1:0]          in_col,
  input  logic signed [sla_pkg::DATA_W-1:0]  in_sample,
  input  logic signed [sla_pkg::DATA_W-1:0]  in_vel_x,
  input  logic signed [sla_pkg::DATA_W-1:0]  in_vel_y,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [sla_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic signed [sla_pkg::DATA_W-1:0]  out_advected_value,
  output logic [sla_pkg::IDX_W-1:0]          out_row,
  output logic [sla_pkg::IDX_W-1:0]          out_col
);
  import sla_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_TX   = 12'b0000_0000_0010,
    S_TY   = 12'b0000_0000_0100,
    S_CY   = 12'b0000_0000_1000,
    S_R00  = 12'b0000_0001_0000,
    S_R01  = 12'b0000_0010_0000,
    S_R10  = 12'b0000_0100_0000,
    S_R11  = 12'b0000_1000_0000,
    S_M11  = 12'b0001_0000_0000,
    S_MA   = 12'b0010_0000_0000,
    S_MB   = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]          grid_cells_r;
  logic [STEP_W-1:0]         step_scale_r;
  logic [IDX_W-1:0]          row_r, col_r;
  logic signed [DATA_W-1:0]  vel_y_r;
  logic [POS_W-1:0]          x_r, y_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [OPB_W-1:0]   ab_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_value_r;
  logic [IDX_W-1:0]          out_row_r, out_col_r;

  logic                      accept;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [DATA_W-1:0]         ram_rdata;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   prod_fl;
  logic signed [ACC_W-1:0]   sum;
  logic [IDX_W-1:0]          n_sat;
  logic [IDX_W-1:0]          i0, j0, i1, j1;
  logic [FRAC_W:0]           s0, s1, t0, t1;

  function automatic logic [POS_W-1:0] trace_pos(
    input logic [IDX_W-1:0]         idx,
    input logic signed [PROD_W-1:0] p,
    input logic [IDX_W-1:0]         n
  );
    logic signed [OFF_W-1:0] off;
    logic signed [OFF_W:0]   pos;
    logic signed [OFF_W:0]   lo;
    logic signed [OFF_W:0]   hi;
    off = p[FRAC_W +: OFF_W];
    pos = $signed({{(OFF_W + 1 - POS_W){1'b0}}, idx, {FRAC_W{1'b0}}}) - $signed({off[OFF_W-1], off});
    lo  = $signed({{(OFF_W + 1 - POS_W){1'b0}}, {IDX_W{1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
    hi  = $signed({{(OFF_W + 1 - POS_W){1'b0}}, n, 1'b1, {(FRAC_W-1){1'b0}}});
    if (pos < lo) begin
      return lo[POS_W-1:0];
    end else if (pos > hi) begin
      return hi[POS_W-1:0];
    end
    return pos[POS_W-1:0];
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign n_sat = (grid_cells_r == '0) ? IDX_W'(1) :
                 (grid_cells_r > GRID_MAX_C) ? GRID_MAX_C : grid_cells_r;

  assign i0 = x_r[FRAC_W +: IDX_W];
  assign j0 = y_r[FRAC_W +: IDX_W];
  assign i1 = i0 + IDX_W'(1);
  assign j1 = j0 + IDX_W'(1);
  assign s1 = {1'b0, x_r[FRAC_W-1:0]};
  assign t1 = {1'b0, y_r[FRAC_W-1:0]};
  assign s0 = {1'b1, {FRAC_W{1'b0}}} - s1;
  assign t0 = {1'b1, {FRAC_W{1'b0}}} - t1;

  assign prod_fl = prod_r[FRAC_W +: ACC_W];
  assign sum     = acc_r + prod_fl;

  assign ram_we = accept && (in_func == FUNC_LOAD) &&
                  ({1'b0, in_row} < (IDX_W+1)'(SIDE)) && ({1'b0, in_col} < (IDX_W+1)'(SIDE));

  always_comb begin
    ram_addr = {in_row, in_col};
    unique case (state_r)
      S_R00:   ram_addr = {i0, j0};
      S_R01:   ram_addr = {i0, j1};
      S_R10:   ram_addr = {i1, j0};
      S_R11:   ram_addr = {i1, j1};
      default: ram_addr = {in_row, in_col};
    endcase
  end

  always_comb begin
    op_a = $signed({1'b0, step_scale_r});
    op_b = OPB_W'($signed(in_vel_x));
    unique case (state_r)
      S_IDLE: begin
        op_a = $signed({1'b0, step_scale_r});
        op_b = OPB_W'($signed(in_vel_x));
      end
      S_TX: begin
        op_a = $signed({1'b0, step_scale_r});
        op_b = OPB_W'(vel_y_r);
      end
      S_R01, S_R11: begin
        op_a = $signed(OPA_W'(t0));
        op_b = OPB_W'($signed(ram_rdata));
      end
      S_R10, S_M11: begin
        op_a = $signed(OPA_W'(t1));
        op_b = OPB_W'($signed(ram_rdata));
      end
      S_MA: begin
        op_a = $signed(OPA_W'(s0));
        op_b = ab_r;
      end
      S_MB: begin
        op_a = $signed(OPA_W'(s1));
        op_b = ab_r;
      end
      default: begin
        op_a = $signed({1'b0, step_scale_r});
        op_b = OPB_W'(vel_y_r);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = (accept && (in_func == FUNC_ADVECT)) ? S_TX : S_IDLE;
      S_TX:    state_nxt = S_TY;
      S_TY:    state_nxt = S_CY;
      S_CY:    state_nxt = S_R00;
      S_R00:   state_nxt = S_R01;
      S_R01:   state_nxt = S_R10;
      S_R10:   state_nxt = S_R11;
      S_R11:   state_nxt = S_M11;
      S_M11:   state_nxt = S_MA;
      S_MA:    state_nxt = S_MB;
      S_MB:    state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grid_cells_r <= GRID_CELLS_RST;
      step_scale_r <= STEP_SCALE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_CELLS: grid_cells_r <= cfg_data[IDX_W-1:0];
          CFG_STEP_SCALE: step_scale_r <= cfg_data[STEP_W-1:0];
          default:        step_scale_r <= step_scale_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r   <= in_row;
      col_r   <= in_col;
      vel_y_r <= in_vel_y;
    end
    case (state_r)
      S_TX:  x_r <= trace_pos(row_r, prod_r, n_sat);
      S_CY:  y_r <= trace_pos(col_r, prod_r, n_sat);
      S_R10: acc_r <= prod_fl;
      S_R11: ab_r <= OPB_W'(sum);
      S_M11: acc_r <= prod_fl;
      S_MA:  ab_r <= OPB_W'(sum);
      S_MB:  acc_r <= prod_fl;
      S_FIN: begin
        if (sum > ACC_W'(32'sh7FFF_FFFF)) begin
          out_value_r <= 32'sh7FFF_FFFF;
        end else if (sum < -ACC_W'(33'sh0_8000_0000)) begin
          out_value_r <= 32'sh8000_0000;
        end else begin
          out_value_r <= sum[DATA_W-1:0];
        end
        out_row_r <= row_r;
        out_col_r <= col_r;
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_advected_value = out_value_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;

  sla_ram #(
    .DW(DATA_W),
    .AW(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .addr   (ram_addr),
    .wdata  (in_sample),
    .rdata_r(ram_rdata)
  );

  sla_mul u_mul (
    .clk   (clk),
    .op_a  (op_a),
    .op_b  (op_b),
    .prod_r(prod_r)
  );

`ifndef NO_ASSERTIONS
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_advect_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == FUNC_ADVECT)) |-> ##12 out_valid)
    else $error("advect result not strobed twelve cycles after acceptance");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == FUNC_LOAD)) |=> !busy)
    else $error("load transfer raised busy");

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE) && $past(state_r == S_FIN))
    else $error("result strobe without a finished advect");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !busy)
    else $error("grid write while an advect is in progress");
`endif

endmodule

@@ tb/semi_lagrangian_advection_test.sv @@
// Self-checking testbench for the semi-Lagrangian advection block: loads grid samples,
// advects cells under several register settings and checks every result in order.
// Depends on sla_pkg and the semi_lagrangian_advection RTL only.
module semi_lagrangian_advection_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam longint ONE_CELL    = 65536;
  localparam longint HALF_CELL   = 32768;
  localparam longint VALUE_MAX   = 64'sd2147483647;
  localparam longint VALUE_MIN   = -64'sd2147483648;
  localparam int     STALL_LIMIT = 2000;
  localparam int     ITEM_TOTAL  = 1900;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
  } cell_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_func = FUNC_LOAD;
  logic [IDX_W-1:0]         in_row = '0;
  logic [IDX_W-1:0]         in_col = '0;
  logic signed [DATA_W-1:0] in_sample = '0;
  logic signed [DATA_W-1:0] in_vel_x = '0;
  logic signed [DATA_W-1:0] in_vel_y = '0;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = CFG_GRID_CELLS;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_advected_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;

  logic [IDX_W-1:0]  cells_reg = GRID_CELLS_RST;
  logic [STEP_W-1:0] step_reg = STEP_SCALE_RST;
  int                field_store [SIDE*SIDE];
  bit                loaded [SIDE*SIDE];
  cell_result_t      pending_cells [$];
  int                mismatches = 0;
  int                items_sent = 0;
  int                stalled_cycles = 0;
  bit                gaps_on = 1'b1;

  semi_lagrangian_advection dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_row             (in_row),
    .in_col             (in_col),
    .in_sample          (in_sample),
    .in_vel_x           (in_vel_x),
    .in_vel_y           (in_vel_y),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_advected_value (out_advected_value),
    .out_row            (out_row),
    .out_col            (out_col)
  );

  always #1 clk = ~clk;

  function automatic longint cells_in_use();
    longint n;
    n = longint'(cells_reg);
    if (n < 1) n = 1;
    if (n > GRID_MAX) n = GRID_MAX;
    return n;
  endfunction

  // Departure point in Q7.16, clamped to the half-cell margin inside the border.
  function automatic longint trace_back(input logic [IDX_W-1:0] idx,
                                        input logic signed [DATA_W-1:0] vel);
    longint pos;
    longint ceiling;
    pos = longint'(idx) * ONE_CELL - ((longint'(step_reg) * longint'(vel)) >>> FRAC_W);
    ceiling = cells_in_use() * ONE_CELL + HALF_CELL;
    if (pos < HALF_CELL) pos = HALF_CELL;
    if (pos > ceiling) pos = ceiling;
    return pos;
  endfunction

  function automatic longint grid_at(input longint i, input longint j);
    return longint'(field_store[i * SIDE + j]);
  endfunction

  function automatic logic signed [DATA_W-1:0] advected(input logic [IDX_W-1:0] r,
                                                        input logic [IDX_W-1:0] c,
                                                        input logic signed [DATA_W-1:0] vx,
                                                        input logic signed [DATA_W-1:0] vy);
    longint x, y, i0, j0, s0, s1, t0, t1, upper, lower, v;
    x = trace_back(r, vx);
    y = trace_back(c, vy);
    i0 = x >>> FRAC_W;
    j0 = y >>> FRAC_W;
    s1 = x & 65535;
    s0 = ONE_CELL - s1;
    t1 = y & 65535;
    t0 = ONE_CELL - t1;
    upper = ((t0 * grid_at(i0, j0)) >>> FRAC_W) + ((t1 * grid_at(i0, j0 + 1)) >>> FRAC_W);
    lower = ((t0 * grid_at(i0 + 1, j0)) >>> FRAC_W)
          + ((t1 * grid_at(i0 + 1, j0 + 1)) >>> FRAC_W);
    v = ((s0 * upper) >>> FRAC_W) + ((s1 * lower) >>> FRAC_W);
    if (v > VALUE_MAX) v = VALUE_MAX;
    if (v < VALUE_MIN) v = VALUE_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1: return $urandom;
      default: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] random_velocity();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return '0;
      default: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] random_coord();
    if ($urandom_range(0, 7) == 0) return IDX_W'($urandom_range(0, SIDE - 1));
    return IDX_W'($urandom_range(0, cells_in_use() + 1));
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic send_item(input logic func, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic signed [DATA_W-1:0] smp,
                           input logic signed [DATA_W-1:0] vx,
                           input logic signed [DATA_W-1:0] vy);
    cell_result_t due;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start     <= 1'b1;
    in_func   <= func;
    in_row    <= r;
    in_col    <= c;
    in_sample <= smp;
    in_vel_x  <= vx;
    in_vel_y  <= vy;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (func == FUNC_LOAD) begin
      field_store[int'(r) * SIDE + int'(c)] = smp;
      loaded[int'(r) * SIDE + int'(c)] = 1'b1;
    end else begin
      due.value = advected(r, c, vx, vy);
      due.row = r;
      due.col = c;
      pending_cells.push_back(due);
    end
  endtask

  // Every sample the interpolation will touch is loaded first; some are refreshed anyway.
  task automatic advect_cell(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                             input logic signed [DATA_W-1:0] vx,
                             input logic signed [DATA_W-1:0] vy);
    longint i0, j0;
    int slot;
    i0 = trace_back(r, vx) >>> FRAC_W;
    j0 = trace_back(c, vy) >>> FRAC_W;
    for (int di = 0; di < 2; di++) begin
      for (int dj = 0; dj < 2; dj++) begin
        slot = int'(i0 + di) * SIDE + int'(j0 + dj);
        if (!loaded[slot] || $urandom_range(0, 15) == 0) begin
          send_item(FUNC_LOAD, IDX_W'(i0 + di), IDX_W'(j0 + dj), random_sample(),
                    $urandom, $urandom);
        end
      end
    end
    send_item(FUNC_ADVECT, r, c, $urandom, vx, vy);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_CELLS) cells_reg = data[IDX_W-1:0];
    else step_reg = data[STEP_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_edge_loads();
    logic signed [DATA_W-1:0] smp;
    write_reg(CFG_GRID_CELLS, 1);
    for (int k = 0; k < 9; k++) begin
      case (k)
        0: smp = 32'sh7FFFFFFF;
        1: smp = 32'sh80000000;
        2: smp = 32'sh00000000;
        3: smp = 32'sh00000001;
        4: smp = 32'shFFFFFFFF;
        5: smp = 32'sh00018000;
        6: smp = 32'shFFFE8000;
        7: smp = 32'sh80000000;
        default: smp = 32'sh7FFFFFFF;
      endcase
      send_item(FUNC_LOAD, IDX_W'(k / 3), IDX_W'(k % 3), smp, '0, '0);
    end
  endtask

  task automatic test_back_trace_cases();
    advect_cell(1, 1, 32'sh00000000, 32'sh00000000);
    advect_cell(0, 0, 32'sh00000000, 32'sh00000000);
    advect_cell(127, 127, 32'sh00000000, 32'sh00000000);
    advect_cell(1, 1, 32'sh7FFFFFFF, 32'sh80000000);
    advect_cell(1, 1, 32'sh00008000, 32'shFFFF4000);
    advect_cell(2, 0, 32'sh00010000, 32'shFFFFFFFF);
  endtask

  task automatic test_cell_count_limits();
    settle();
    write_reg(CFG_GRID_CELLS, 0);
    advect_cell(1, 1, 32'shFFFE0000, 32'sh00020000);
    settle();
    write_reg(CFG_GRID_CELLS, 127);
    advect_cell(1, 1, 32'shFFFE0000, 32'sh00020000);
    advect_cell(1, 1, 32'sh80000000, 32'sh80000000);
  endtask

  task automatic test_step_extremes();
    settle();
    write_reg(CFG_STEP_SCALE, 0);
    advect_cell(1, 1, 32'sh7FFFFFFF, 32'sh80000000);
    settle();
    write_reg(CFG_STEP_SCALE, 24'hFFFFFF);
    advect_cell(0, 2, 32'sh00000001, 32'shFFFFFFFF);
    advect_cell(5, 5, 32'sh7FFFFFFF, 32'sh00000000);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cells, input logic [CFG_W-1:0] step,
                           input bit gaps, input int count);
    int stop_at;
    int pick;
    settle();
    write_reg(CFG_GRID_CELLS, cells);
    write_reg(CFG_STEP_SCALE, step);
    gaps_on = gaps;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_item(FUNC_LOAD, IDX_W'($urandom_range(0, SIDE - 1)),
                  IDX_W'($urandom_range(0, SIDE - 1)), random_sample(), $urandom, $urandom);
      end else if (pick == 1) begin
        settle();
      end else begin
        advect_cell(random_coord(), random_coord(), random_velocity(), random_velocity());
      end
    end
  endtask

  task automatic test_random_phases();
    int share;
    share = (ITEM_TOTAL - items_sent) / 8;
    run_phase(1, 0, 1'b1, share);
    run_phase(126, 24'hFFFFFF, 1'b0, share);
    run_phase(4, 65536, 1'b1, share);
    run_phase($urandom_range(2, 10), $urandom_range(0, 24'hFFFFFF), 1'b1, share);
    run_phase(0, $urandom_range(0, 24'h03FFFF), 1'b0, share);
    run_phase(127, 65536, 1'b1, share);
    run_phase($urandom_range(1, 126), $urandom_range(0, 24'h03FFFF), 1'b1, share);
    run_phase(3, $urandom_range(0, 24'h03FFFF), 1'b0, share);
  endtask

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_valid) begin
      if (pending_cells.size() == 0) begin
        flag_error($sformatf("result for row %0d col %0d with nothing pending",
                             out_row, out_col));
      end else begin
        want = pending_cells.pop_front();
        if (out_advected_value !== want.value)
          flag_error($sformatf("advected_value at row %0d col %0d: expected %0d, got %0d",
                               want.row, want.col, want.value, out_advected_value));
        if (out_row !== want.row)
          flag_error($sformatf("out_row: expected %0d, got %0d", want.row, out_row));
        if (out_col !== want.col)
          flag_error($sformatf("out_col: expected %0d, got %0d", want.col, out_col));
      end
    end
  end

  // A transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("semi_lagrangian_advection test failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_loads();
    test_back_trace_cases();
    test_cell_count_limits();
    test_step_extremes();
    test_random_phases();
    settle();
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("semi_lagrangian_advection test passed");
    end else begin
      $display("semi_lagrangian_advection test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sla_pkg.sv
rtl/sla_ram.sv
rtl/sla_mul.sv
rtl/semi_lagrangian_advection.sv
tb/semi_lagrangian_advection_test.sv
